// File: rtl/core/perceptron_branch_predictor_unit_assert.svh
// Assertion macros used by the top level of the perceptron predictor RTL
`ifndef PERCEPTRON_BRANCH_PREDICTOR_UNIT_ASSERT_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PBP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbp assertion failed");

// next-cycle implication, checked outside reset
`define PBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbp assertion failed");

`endif

// File: rtl/core/pbp_pkg.sv
// Package: types, constants and defaults of the perceptron predictor
`timescale 1ns / 1ps
package pbp_pkg;

   localparam int HISTORY_LENGTH_DEF = 62;
   localparam int ROW_COUNT_DEF      = 1024;

   localparam int PC_W     = 32;
   localparam int WEIGHT_W = 8;
   localparam int SUM_W    = 14;
   localparam int THR_W    = 13;
   // wide enough for 65 weights of magnitude 128
   localparam int ACC_W    = 15;

   localparam int SUM_MAX       = 8191;
   localparam int SUM_MIN       = -8192;
   localparam int WEIGHT_MAX    = 127;
   localparam int WEIGHT_MIN    = -128;
   localparam int THR_RESET     = 133;

   localparam logic REQ_PREDICT = 1'b0;
   localparam logic REQ_UPDATE  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW,
      ST_STREAM,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic start;
      logic row_step;
      logic issue;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic row_done;
      logic issue_last;
      logic need_stream;
   } sts_type;

endpackage

// File: rtl/core/pbp_req_if.sv
// Request channel interface
`timescale 1ns / 1ps
interface pbp_req_if;
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [pbp_pkg::PC_W-1:0] pc;
   logic                     actual_taken;
   logic                     predicted_taken;

   modport source (output valid, req_type, pc, actual_taken, predicted_taken, input ready);
   modport sink   (input valid, req_type, pc, actual_taken, predicted_taken, output ready);
endinterface

// File: rtl/core/pbp_rsp_if.sv
// Response channel interface
`timescale 1ns / 1ps
interface pbp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             predict_taken;
   logic signed [pbp_pkg::SUM_W-1:0] perceptron_sum;
   logic                             trained;

   modport source (output valid, predict_taken, perceptron_sum, trained, input ready);
   modport sink   (input valid, predict_taken, perceptron_sum, trained, output ready);
endinterface

// File: rtl/core/pbp_ctrl.sv
// Controller state machine of the perceptron predictor
`timescale 1ns / 1ps
module pbp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  pbp_pkg::sts_type sts,
   output pbp_pkg::cmd_type cmd
);

   pbp_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbp_pkg::ST_CLEAR: begin
            if (sts.clear_last) state_in = pbp_pkg::ST_IDLE;
         end
         pbp_pkg::ST_IDLE: begin
            if (req_valid) state_in = pbp_pkg::ST_ROW;
         end
         pbp_pkg::ST_ROW: begin
            if (sts.row_done) begin
               state_in = sts.need_stream ? pbp_pkg::ST_STREAM : pbp_pkg::ST_FINISH;
            end
         end
         pbp_pkg::ST_STREAM: begin
            if (sts.issue_last) state_in = pbp_pkg::ST_DRAIN;
         end
         pbp_pkg::ST_DRAIN: begin
            state_in = pbp_pkg::ST_FINISH;
         end
         pbp_pkg::ST_FINISH: begin
            if (out_free) state_in = pbp_pkg::ST_IDLE;
         end
         default: begin
            state_in = pbp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pbp_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         pbp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         pbp_pkg::ST_ROW: begin
            cmd.row_step = 1'b1;
         end
         pbp_pkg::ST_STREAM: begin
            cmd.issue = 1'b1;
         end
         pbp_pkg::ST_FINISH: begin
            cmd.commit = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbp_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/pbp_dpath.sv
// Datapath: weight memory, row index unit, dot-product accumulator, trainer
`timescale 1ns / 1ps
module pbp_dpath #(
   parameter int HISTORY_LENGTH = pbp_pkg::HISTORY_LENGTH_DEF,
   parameter int ROW_COUNT      = pbp_pkg::ROW_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_type,
   input  logic [pbp_pkg::PC_W-1:0]         pc,
   input  logic                             actual_taken,
   input  logic                             predicted_taken,
   input  logic                             csr_we,
   input  logic [pbp_pkg::THR_W-1:0]        csr_wdata,
   input  pbp_pkg::cmd_type                 cmd,
   output pbp_pkg::sts_type                 sts,
   output logic                             rsp_predict_taken,
   output logic signed [pbp_pkg::SUM_W-1:0] rsp_perceptron_sum,
   output logic                             rsp_trained
);

   localparam int RB    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int KW    = $clog2(HISTORY_LENGTH + 1);
   localparam int AW    = RB + KW;
   localparam int DEPTH = 1 << AW;
   localparam int WW    = pbp_pkg::WEIGHT_W;
   localparam int ACW   = pbp_pkg::ACC_W;
   localparam int SW    = pbp_pkg::SUM_W;

   localparam logic signed [ACW-1:0] ACC_HI = ACW'(pbp_pkg::SUM_MAX);
   localparam logic signed [ACW-1:0] ACC_LO = ACW'(pbp_pkg::SUM_MIN);
   localparam logic signed [WW-1:0]  W_HI   = WW'(pbp_pkg::WEIGHT_MAX);
   localparam logic signed [WW-1:0]  W_LO   = WW'(pbp_pkg::WEIGHT_MIN);

   // state and item registers
   logic [pbp_pkg::THR_W-1:0]  thr_ff;
   logic [HISTORY_LENGTH-1:0]  hist_ff, hist_in;
   logic signed [SW-1:0]       kept_ff;
   logic                       is_upd_ff, act_ff, train_ff;
   logic [RB-1:0]              row_idx;

   // stream registers
   logic [KW-1:0]              k_ff, k_d_ff;
   logic                       rd_valid_ff;
   logic [HISTORY_LENGTH:0]    sign_ff;
   logic signed [ACW-1:0]      acc_ff, acc_in;
   logic [AW-1:0]              clr_ff;

   // memory
   logic signed [WW-1:0]       weight_mem [DEPTH];
   logic signed [WW-1:0]       rdata_ff;
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic signed [WW-1:0]       mem_wdata;
   logic signed [WW-1:0]       w_new;
   logic                       w_up;

   logic [SW-1:0]              mag;
   logic                       train_now;
   logic signed [SW-1:0]       sum_sat, out_sum;
   logic signed [ACW-1:0]      term;
   logic [HISTORY_LENGTH:0]    hist_shift;

   // ---- row index: pc mod ROW_COUNT ----
   generate
      if ((ROW_COUNT & (ROW_COUNT - 1)) == 0) begin : g_row_mask
         logic [RB-1:0] row_ff;
         always_ff @(posedge clock) begin
            if (cmd.start) row_ff <= pc[RB-1:0];
         end
         assign row_idx      = row_ff;
         assign sts.row_done = 1'b1;
      end else begin : g_row_div
         // quotient by reciprocal multiply; the estimate is low by at most one,
         // so one compare and subtract finishes the remainder
         localparam int PW = pbp_pkg::PC_W;
         localparam logic [PW-1:0] RECIP = PW'((64'd1 << PW) / ROW_COUNT);
         localparam logic [RB:0]   RC    = (RB + 1)'(ROW_COUNT);
         logic [PW-1:0]   pc_ff;
         logic [2*PW-1:0] prod;
         logic [PW-1:0]   quo_ff;
         logic [RB:0]     qd_lo;
         logic [RB:0]     rem_est;
         logic [RB:0]     rem_ff;
         logic [RB-1:0]   row_ff;
         logic [1:0]      step_ff;
         assign prod    = {{PW{1'b0}}, pc_ff} * {{PW{1'b0}}, RECIP};
         // remainder estimate is below 2*ROW_COUNT, so the low bits are enough
         assign qd_lo   = quo_ff[RB:0] * RC;
         assign rem_est = pc_ff[RB:0] - qd_lo;
         always_ff @(posedge clock) begin
            if (reset) begin
               step_ff <= '0;
            end else if (cmd.start) begin
               step_ff <= '0;
            end else if (cmd.row_step && (step_ff != 2'd3)) begin
               step_ff <= step_ff + 1'b1;
            end
         end
         always_ff @(posedge clock) begin
            if (cmd.start) pc_ff <= pc;
            if (cmd.row_step) begin
               case (step_ff)
                  2'd0: begin
                     quo_ff <= prod[2*PW-1:PW];
                  end
                  2'd1: begin
                     rem_ff <= rem_est;
                  end
                  2'd2: begin
                     row_ff <= (rem_ff >= RC) ? RB'(rem_ff - RC) : rem_ff[RB-1:0];
                  end
                  default: begin
                  end
               endcase
            end
         end
         assign row_idx      = row_ff;
         assign sts.row_done = (step_ff == 2'd3);
      end
   endgenerate

   // ---- training decision on the kept sum ----
   assign mag       = kept_ff[SW-1] ? (~kept_ff + 1'b1) : kept_ff;
   assign train_now = (actual_taken != predicted_taken) || (mag <= {1'b0, thr_ff});

   assign sts.need_stream = !is_upd_ff || train_ff;
   assign sts.issue_last  = (k_ff == KW'(HISTORY_LENGTH));
   assign sts.clear_last  = &clr_ff;

   // ---- per-weight arithmetic on the word just read ----
   assign term   = sign_ff[0] ? {{(ACW-WW){rdata_ff[WW-1]}}, rdata_ff}
                              : -{{(ACW-WW){rdata_ff[WW-1]}}, rdata_ff};
   assign acc_in = acc_ff + term;

   assign w_up  = (sign_ff[0] == act_ff);
   always_comb begin
      if (w_up) w_new = (rdata_ff == W_HI) ? W_HI : rdata_ff + 1'b1;
      else      w_new = (rdata_ff == W_LO) ? W_LO : rdata_ff - 1'b1;
   end

   always_comb begin
      if (cmd.clear) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = rd_valid_ff && is_upd_ff;
         mem_waddr = {row_idx, k_d_ff};
         mem_wdata = w_new;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) weight_mem[mem_waddr] <= mem_wdata;
      rdata_ff <= weight_mem[{row_idx, k_ff}];
   end

   // ---- result and commit ----
   always_comb begin
      if (acc_ff > ACC_HI)      sum_sat = SW'(ACC_HI);
      else if (acc_ff < ACC_LO) sum_sat = SW'(ACC_LO);
      else                      sum_sat = acc_ff[SW-1:0];
   end
   assign out_sum    = is_upd_ff ? kept_ff : sum_sat;
   assign hist_shift = {hist_ff, act_ff};
   assign hist_in    = hist_shift[HISTORY_LENGTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= pbp_pkg::THR_W'(pbp_pkg::THR_RESET);
         hist_ff     <= '0;
         kept_ff     <= '0;
         clr_ff      <= '0;
         rd_valid_ff <= 1'b0;
         k_ff        <= '0;
      end else begin
         if (csr_we) thr_ff <= csr_wdata;
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         rd_valid_ff <= cmd.issue;
         if (cmd.start) k_ff <= '0;
         else if (cmd.issue) k_ff <= k_ff + 1'b1;
         if (cmd.commit) begin
            if (is_upd_ff) hist_ff <= hist_in;
            else           kept_ff <= sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         is_upd_ff <= (req_type == pbp_pkg::REQ_UPDATE);
         act_ff    <= actual_taken;
         train_ff  <= (req_type == pbp_pkg::REQ_UPDATE) && train_now;
         sign_ff   <= {hist_ff, 1'b1};
         acc_ff    <= '0;
      end else if (rd_valid_ff) begin
         sign_ff   <= sign_ff >> 1;
         acc_ff    <= acc_in;
      end
      if (cmd.issue) k_d_ff <= k_ff;
      if (cmd.commit) begin
         rsp_predict_taken  <= !out_sum[SW-1];
         rsp_perceptron_sum <= out_sum;
         rsp_trained        <= is_upd_ff && train_ff;
      end
   end

endmodule

// File: rtl/core/perceptron_branch_predictor_unit.sv
// Top level of the perceptron branch predictor
`timescale 1ns / 1ps
// Perceptron branch predictor. Each request word returns one response word. After reset the
// weight memory, 2^(clog2(ROW_COUNT) + clog2(HISTORY_LENGTH+1)) words (65536 at defaults), is
// swept to zero one weight a cycle, and no request is taken meanwhile. A predict request
// reads its row through the 8-bit read port of the weight memory, which streams the row's
// HISTORY_LENGTH+1 weights one per cycle. A training update streams the row the same way,
// writing back each trained weight; an update that does not train skips the stream. When
// ROW_COUNT is not a power of two, the row index comes from a reciprocal multiply and one
// correction step, with the quotient, the remainder estimate and the corrected row
// registered in turn. The response register frees the request side, so a new request may be
// accepted while the previous response is still waiting; a request stalls before its
// response only while the earlier response word is still unread.
`include "perceptron_branch_predictor_unit_assert.svh"
module perceptron_branch_predictor_unit #(
   parameter int HISTORY_LENGTH = pbp_pkg::HISTORY_LENGTH_DEF,
   parameter int ROW_COUNT      = pbp_pkg::ROW_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   pbp_req_if.sink                   req_if,
   pbp_rsp_if.source                 rsp_if,
   input  logic                      csr_we,
   input  logic [pbp_pkg::THR_W-1:0] csr_wdata
);

   pbp_pkg::cmd_type cmd;
   pbp_pkg::sts_type sts;

   pbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pbp_dpath #(
      .HISTORY_LENGTH (HISTORY_LENGTH),
      .ROW_COUNT      (ROW_COUNT)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_type           (req_if.req_type),
      .pc                 (req_if.pc),
      .actual_taken       (req_if.actual_taken),
      .predicted_taken    (req_if.predicted_taken),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_predict_taken  (rsp_if.predict_taken),
      .rsp_perceptron_sum (rsp_if.perceptron_sum),
      .rsp_trained        (rsp_if.trained)
   );

   // no request during the memory sweep
   `PBP_ASSERT_SAME(a_no_req_in_clear, clock, reset, cmd.clear, !req_if.ready)
   // a new word never overwrites one still waiting
   `PBP_ASSERT_SAME(a_no_rsp_overwrite, clock, reset, cmd.commit, !rsp_if.valid || rsp_if.ready)
   // the row stream stops after its last weight
   `PBP_ASSERT_NEXT(a_stream_ends, clock, reset, cmd.issue && sts.issue_last, !cmd.issue)
   // direction bit agrees with the sign of the reported sum
   `PBP_ASSERT_SAME(a_dir_matches_sum, clock, reset, rsp_if.valid, rsp_if.predict_taken == !rsp_if.perceptron_sum[pbp_pkg::SUM_W-1])

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the perceptron branch predictor unit
`timescale 1ns / 1ps
module tb_top;

   localparam int HIST         = pbp_pkg::HISTORY_LENGTH_DEF;
   localparam int ROWS         = pbp_pkg::ROW_COUNT_DEF;
   localparam int TAPS         = HIST + 1;
   localparam int ROW_BITS     = $clog2(ROWS);
   localparam int PC_W         = pbp_pkg::PC_W;
   localparam int SUM_W        = pbp_pkg::SUM_W;
   localparam int THR_W        = pbp_pkg::THR_W;
   localparam int WEIGHT_W     = pbp_pkg::WEIGHT_W;
   localparam int SUM_MAX      = pbp_pkg::SUM_MAX;
   localparam int SUM_MIN      = pbp_pkg::SUM_MIN;
   localparam int WEIGHT_MAX   = pbp_pkg::WEIGHT_MAX;
   localparam int WEIGHT_MIN   = pbp_pkg::WEIGHT_MIN;
   // cycles with no word moving before the bench gives up
   localparam int STALL_LIMIT  = 200000;
   localparam int SETTLE       = HIST + 12;
   localparam int SHOWN_FAULTS = 10;
   localparam int POOL         = 8;

   typedef struct packed {
      logic             taken;
      logic [SUM_W-1:0] total;
      logic             trained;
   } verdict_type;

   typedef enum int {
      BR_MOSTLY_TAKEN, BR_MOSTLY_NOT, BR_LOOP, BR_ALTERNATE, BR_COIN
   } branch_kind_type;
   typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [THR_W-1:0] csr_wdata;

   pbp_req_if req_if ();
   pbp_rsp_if rsp_if ();

   perceptron_branch_predictor_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic signed [WEIGHT_W-1:0] weight_mem [ROWS][TAPS];
   logic [HIST-1:0]            history   = '0;
   int                         held_sum  = 0;
   logic [THR_W-1:0]           threshold = THR_W'(pbp_pkg::THR_RESET);

   verdict_type expected_verdicts [$];
   int          fault_count  = 0;
   int          quiet_cycles = 0;
   int          burst_left   = 0;
   int          hold_request = 0;
   int          hold_left    = 0;
   rx_mode_type rx_mode      = RX_OPEN;
   int          rx_mode_left = 0;
   int          rx_phase     = 0;

   // branches used to build realistic predict/update pairs
   int              br_row    [POOL];
   branch_kind_type br_kind   [POOL];
   int              br_period [POOL];
   int              br_count  [POOL];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void report_fault(input string what);
      fault_count++;
      if (fault_count <= SHOWN_FAULTS) $display("ERROR @%0t: %s", $time, what);
   endfunction

   function automatic void check_field(input string field, input int got, input int want);
      if (got != want) report_fault($sformatf("%s expected %0d got %0d", field, want, got));
   endfunction

   function automatic verdict_type predictor_step(input logic kind, input logic [PC_W-1:0] pc,
                                                  input logic actual, input logic guess);
      int          row;
      int          acc;
      int          w;
      int          k;
      logic        plus;
      verdict_type v;
      row = int'(pc % ROWS);
      v.trained = 1'b0;
      if (kind == pbp_pkg::REQ_PREDICT) begin
         acc = 0;
         for (k = 0; k < TAPS; k++) begin
            plus = (k == 0) ? 1'b1 : history[k-1];
            w = weight_mem[row][k];
            acc += plus ? w : -w;
         end
         if (acc > SUM_MAX) acc = SUM_MAX;
         if (acc < SUM_MIN) acc = SUM_MIN;
         held_sum = acc;
      end else begin
         if (actual != guess || (held_sum < 0 ? -held_sum : held_sum) <= int'(threshold)) begin
            v.trained = 1'b1;
            for (k = 0; k < TAPS; k++) begin
               plus = (k == 0) ? 1'b1 : history[k-1];
               w = weight_mem[row][k];
               w += (plus == actual) ? 1 : -1;
               if (w > WEIGHT_MAX) w = WEIGHT_MAX;
               if (w < WEIGHT_MIN) w = WEIGHT_MIN;
               weight_mem[row][k] = WEIGHT_W'(w);
            end
         end
         history = {history[HIST-2:0], actual};
      end
      v.taken = (held_sum >= 0);
      v.total = SUM_W'(held_sum);
      return v;
   endfunction

   // Offers one word in bursts with random gaps; predicts the response once accepted.
   task automatic send_word(input logic kind, input logic [PC_W-1:0] pc, input logic actual,
                            input logic guess, output verdict_type v);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 4) == 0) gap = 0;
         else if ($urandom_range(0, 9) == 0) gap = $urandom_range(30, 90);
         else gap = $urandom_range(1, 10);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_if.valid           <= 1'b1;
      req_if.req_type        <= kind;
      req_if.pc              <= pc;
      req_if.actual_taken    <= actual;
      req_if.predicted_taken <= guess;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      burst_left--;
      v = predictor_step(kind, pc, actual, guess);
      expected_verdicts.push_back(v);
   endtask

   task automatic wait_results_home();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      threshold = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic shuffle_branches();
      int b;
      for (b = 0; b < POOL; b++) begin
         br_row[b]    = $urandom_range(0, ROWS - 1);
         br_kind[b]   = branch_kind_type'($urandom_range(0, 4));
         br_period[b] = $urandom_range(2, 12);
         br_count[b]  = 0;
      end
      // two branches alias onto one row
      br_row[POOL-1] = br_row[0];
   endtask

   // predict, resolve the branch, then update with the direction that was predicted
   task automatic run_branch(input int b);
      logic [PC_W-1:0] pc;
      logic            outcome;
      verdict_type     guess_v;
      verdict_type     upd_v;
      pc = ($urandom() << ROW_BITS) | PC_W'(br_row[b]);
      send_word(pbp_pkg::REQ_PREDICT, pc, 1'($urandom()), 1'($urandom()), guess_v);
      br_count[b]++;
      case (br_kind[b])
         BR_MOSTLY_TAKEN: outcome = ($urandom_range(0, 9) != 0);
         BR_MOSTLY_NOT:   outcome = ($urandom_range(0, 9) == 0);
         BR_LOOP:         outcome = (br_count[b] % br_period[b]) != 0;
         BR_ALTERNATE:    outcome = (br_count[b] % 2) != 0;
         default:         outcome = 1'($urandom());
      endcase
      send_word(pbp_pkg::REQ_UPDATE, pc, outcome, guess_v.taken, upd_v);
   endtask

   task automatic send_noise();
      verdict_type     v;
      logic [PC_W-1:0] pc;
      if ($urandom_range(0, 1) == 0) begin
         send_word(1'($urandom()), $urandom(), 1'($urandom()), 1'($urandom()), v);
      end else begin
         // stray update on a live row with no predict in front of it
         pc = ($urandom() << ROW_BITS) | PC_W'(br_row[$urandom_range(0, POOL - 1)]);
         send_word(pbp_pkg::REQ_UPDATE, pc, 1'($urandom()), 1'($urandom()), v);
      end
   endtask

   task automatic test_directed_defaults();
      verdict_type v;
      // update before any predict
      send_word(pbp_pkg::REQ_UPDATE,  32'h0000_0000, 1'b1, 1'b0, v);
      send_word(pbp_pkg::REQ_PREDICT, 32'h0000_0000, 1'b0, 1'b0, v);
      send_word(pbp_pkg::REQ_UPDATE,  32'h0000_0000, 1'b1, v.taken, v);
      send_word(pbp_pkg::REQ_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1, v);
      send_word(pbp_pkg::REQ_UPDATE,  32'hFFFF_FFFF, 1'b0, 1'b1, v);
      send_word(pbp_pkg::REQ_PREDICT, 32'hAAAA_AAAA, 1'b0, 1'b1, v);
      send_word(pbp_pkg::REQ_UPDATE,  32'h5555_5555, 1'b1, 1'b1, v);
      // high bits ignored: row 0
      send_word(pbp_pkg::REQ_PREDICT, 32'h8000_0000, 1'b1, 1'b0, v);
      send_word(pbp_pkg::REQ_UPDATE,  32'h0000_0400, 1'b0, 1'b0, v);
      send_word(pbp_pkg::REQ_PREDICT, 32'h0000_03FF, 1'b0, 1'b0, v);
      wait_results_home();
   endtask

   task automatic test_threshold_extremes();
      verdict_type v;
      write_threshold(13'h0000);
      send_word(pbp_pkg::REQ_PREDICT, 32'h0000_0000, 1'b0, 1'b0, v);
      // correct and confident: no training unless the sum is exactly zero
      send_word(pbp_pkg::REQ_UPDATE,  32'h0000_0000, v.taken, v.taken, v);
      send_word(pbp_pkg::REQ_PREDICT, 32'h0000_0123, 1'b0, 1'b0, v);
      // zero sum still trains
      send_word(pbp_pkg::REQ_UPDATE,  32'h0000_0123, 1'b1, 1'b1, v);
      wait_results_home();
      write_threshold(13'h1FFF);
      send_word(pbp_pkg::REQ_PREDICT, 32'h0000_0000, 1'b1, 1'b1, v);
      send_word(pbp_pkg::REQ_UPDATE,  32'h0000_0000, v.taken, v.taken, v);
      send_word(pbp_pkg::REQ_PREDICT, 32'h0000_07FF, 1'b0, 1'b0, v);
      send_word(pbp_pkg::REQ_UPDATE,  32'h0000_07FF, 1'b0, 1'b1, v);
      wait_results_home();
   endtask

   // every update trains: push one row to the top, then all the way down
   task automatic test_weight_saturation();
      logic [PC_W-1:0] pc;
      verdict_type     v;
      int              row;
      int              n;
      write_threshold(13'h1FFF);
      row = $urandom_range(0, ROWS - 1);
      for (n = 0; n < 450; n++) begin
         pc = ($urandom() << ROW_BITS) | PC_W'(row);
         if ($urandom_range(0, 2) == 0) begin
            send_word(pbp_pkg::REQ_PREDICT, pc, 1'($urandom()), 1'($urandom()), v);
         end
         send_word(pbp_pkg::REQ_UPDATE, pc, n < 190, 1'($urandom()), v);
      end
      wait_results_home();
   endtask

   // response side held off long enough for the unit to back up into the request side
   task automatic test_backpressure();
      int n;
      shuffle_branches();
      hold_request = 600;
      for (n = 0; n < 8; n++) run_branch($urandom_range(0, POOL - 1));
      wait_results_home();
   endtask

   task automatic test_random_traffic();
      logic [THR_W-1:0] settings [6];
      int               p;
      int               sent;
      settings = '{THR_W'(pbp_pkg::THR_RESET), THR_W'($urandom_range(1, 8190)), 13'h0000,
                   13'h1FFF, THR_W'($urandom_range(0, 40)), THR_W'($urandom_range(100, 300))};
      for (p = 0; p < 6; p++) begin
         write_threshold(settings[p]);
         shuffle_branches();
         sent = 0;
         while (sent < 220) begin
            if ($urandom_range(0, 99) < 85) begin
               run_branch($urandom_range(0, POOL - 1));
               sent += 2;
            end else begin
               send_noise();
               sent++;
            end
         end
         wait_results_home();
      end
   endtask

   // response checker
   always @(posedge clock) begin : rsp_compare
      verdict_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_verdicts.size() == 0) begin
            report_fault($sformatf("unexpected word: taken %0b sum %0d trained %0b",
                                   rsp_if.predict_taken, rsp_if.perceptron_sum, rsp_if.trained));
         end else begin
            want = expected_verdicts.pop_front();
            check_field("predict_taken", int'(rsp_if.predict_taken), int'(want.taken));
            check_field("perceptron_sum", int'(rsp_if.perceptron_sum), int'($signed(want.total)));
            check_field("trained", int'(rsp_if.trained), int'(want.trained));
         end
      end
   end

   // receiver stall pattern, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(100, 1500);
         end
         rx_mode_left--;
         rx_phase++;
         case (rx_mode)
            RX_OPEN:     rsp_if.ready <= 1'b1;
            RX_COIN:     rsp_if.ready <= 1'($urandom());
            RX_PERIODIC: rsp_if.ready <= (rx_phase % 7) < 4;
            default:     rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("perceptron_branch_predictor_unit verification failed");
         $finish;
      end
   end

   initial begin
      int r;
      int k;
      reset                  <= 1'b1;
      csr_we                 <= 1'b0;
      csr_wdata              <= '0;
      req_if.valid           <= 1'b0;
      req_if.req_type        <= pbp_pkg::REQ_PREDICT;
      req_if.pc              <= '0;
      req_if.actual_taken    <= 1'b0;
      req_if.predicted_taken <= 1'b0;
      for (r = 0; r < ROWS; r++)
         for (k = 0; k < TAPS; k++) weight_mem[r][k] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_defaults();
      test_threshold_extremes();
      test_weight_saturation();
      test_backpressure();
      test_random_traffic();

      repeat (SETTLE) @(posedge clock);
      while (expected_verdicts.size() != 0) begin
         report_fault($sformatf("word never returned: taken %0b sum %0d trained %0b",
                                expected_verdicts[0].taken, $signed(expected_verdicts[0].total),
                                expected_verdicts[0].trained));
         void'(expected_verdicts.pop_front());
      end
      if (fault_count == 0) begin
         $display("perceptron_branch_predictor_unit verification clean");
      end else begin
         $display("perceptron_branch_predictor_unit verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/pbp_pkg.sv
rtl/core/pbp_req_if.sv
rtl/core/pbp_rsp_if.sv
rtl/core/pbp_ctrl.sv
rtl/core/pbp_dpath.sv
rtl/core/perceptron_branch_predictor_unit.sv
verif/tb_top.sv
